// ===== hw/rtl/iur_pkg.sv =====
package iur_pkg;

  // default table sizes
  localparam int unsigned MaxUnitsDef   = 8;
  localparam int unsigned MaxRangesDef  = 16;
  localparam int unsigned MaxDevicesDef = 32;

  // unit numbers are three bits wide, so at most eight can exist
  localparam int unsigned UnitW     = 3;
  localparam int unsigned UnitCodes = 1 << UnitW;

  typedef logic [UnitW-1:0] unit_t;
  typedef logic [UnitCodes-1:0] unit_mask_t;

  typedef enum logic [1:0] {
    OP_ADD_UNIT   = 2'd0,
    OP_ADD_RANGE  = 2'd1,
    OP_ADD_DEVICE = 2'd2,
    OP_LOOKUP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_UNKNOWN   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] segment;
    logic [7:0]  bus;
    logic [7:0]  devfn;
    unit_t       unit;
    logic        include_all;
    logic [7:0]  range_start;
    logic [7:0]  range_end;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    unit_t      unit_index;
  } rsp_t;

  // table entries as held in the memories
  typedef struct packed {
    logic [15:0] segment;
    logic        all_flag;
  } unit_entry_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] last;
    unit_t      owner;
  } range_entry_t;

  typedef struct packed {
    logic [7:0] bus;
    logic [7:0] devfn;
    unit_t      owner;
  } device_entry_t;

endpackage

// ===== hw/rtl/iur_ram.sv =====
module iur_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/iommu_unit_resolver_core.sv =====
// remapping unit resolver: maps a pci requester (segment, bus, devfn) to the
// remapping unit that covers it, from three tables filled by commands
// - command channel: req_i is taken at a clock edge with start high and busy
//   low; opcode selects add unit, add bus range, add device or lookup
// - result channel: rsp_o is valid for exactly one cycle while rsp_valid_o is
//   high; the receiver cannot stall it, so there is no back-pressure at all
// - add commands write their table memory at the transfer edge and answer in
//   the next cycle; busy stays low, so a command per cycle is accepted
// - a lookup sweeps the three memories one entry a cycle through the single
//   read port of each: unit table (segment match and include-all masks), then
//   bus ranges, then explicit devices; each sweep waits for the registered
//   read of its last entry before handing over, an empty table is skipped,
//   and a resolve step then picks the answer; busy is high through the
//   sweeps and the resolve step, so lookups run one at a time
// - tables are only written while busy is low, so a sweep never meets a write
//   to the entry it reads
// - reset empties all three tables (the fill counts go to zero); no clearing
//   pass is needed since only entries below a count are ever read
module iommu_unit_resolver_core #(
  parameter int unsigned MAX_UNITS   = iur_pkg::MaxUnitsDef,
  parameter int unsigned MAX_RANGES  = iur_pkg::MaxRangesDef,
  parameter int unsigned MAX_DEVICES = iur_pkg::MaxDevicesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  iur_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output iur_pkg::rsp_t rsp_o
);

  // address and count widths per table
  localparam int unsigned UAW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned RAW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned DAW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned UCW = $clog2(MAX_UNITS + 1);
  localparam int unsigned RCW = $clog2(MAX_RANGES + 1);
  localparam int unsigned DCW = $clog2(MAX_DEVICES + 1);
  localparam int unsigned SW0 = (UCW > RCW) ? UCW : RCW;
  localparam int unsigned SW  = (SW0 > DCW) ? SW0 : DCW;
  localparam int unsigned CMW = (UCW > iur_pkg::UnitW) ? UCW : iur_pkg::UnitW;
  localparam int unsigned UEW = $bits(iur_pkg::unit_entry_t);
  localparam int unsigned REW = $bits(iur_pkg::range_entry_t);
  localparam int unsigned DEW = $bits(iur_pkg::device_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UNITS,
    S_RANGES,
    S_DEVICES,
    S_RESOLVE
  } state_e;

  state_e state_q;

  // fill counts
  logic [UCW-1:0] unit_cnt_q;
  logic [RCW-1:0] range_cnt_q;
  logic [DCW-1:0] dev_cnt_q;

  // sweep control
  logic [SW-1:0]      scan_q;
  logic               pend_q;
  iur_pkg::unit_t     pidx_q;

  // lookup key and gathered evidence
  logic [15:0]         seg_q;
  logic [7:0]          bus_q;
  logic [7:0]          devfn_q;
  iur_pkg::unit_mask_t seg_mask_q;
  iur_pkg::unit_mask_t all_mask_q;
  iur_pkg::unit_mask_t range_mask_q;
  logic                dev_hit_q;
  iur_pkg::unit_t      dev_unit_q;

  logic          rsp_valid_d;
  logic          rsp_valid_q;
  iur_pkg::rsp_t rsp_q;

  // memory ports
  iur_pkg::unit_entry_t   unit_wdata, unit_rdata;
  iur_pkg::range_entry_t  range_wdata, range_rdata;
  iur_pkg::device_entry_t dev_wdata, dev_rdata;
  logic unit_we, range_we, dev_we;

  // command decode
  logic          accept;
  logic          unit_full, range_full, dev_full, unit_unknown;
  iur_pkg::rsp_t add_rsp;
  iur_pkg::rsp_t lookup_rsp;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign unit_full    = (unit_cnt_q == UCW'(MAX_UNITS));
  assign range_full   = (range_cnt_q == RCW'(MAX_RANGES));
  assign dev_full     = (dev_cnt_q == DCW'(MAX_DEVICES));
  assign unit_unknown = (CMW'(req_i.unit) >= CMW'(unit_cnt_q));

  assign unit_we  = accept && (req_i.opcode == iur_pkg::OP_ADD_UNIT) && !unit_full;
  assign range_we = accept && (req_i.opcode == iur_pkg::OP_ADD_RANGE)
                    && !unit_unknown && !range_full;
  assign dev_we   = accept && (req_i.opcode == iur_pkg::OP_ADD_DEVICE)
                    && !unit_unknown && !dev_full;

  // a result leaves the cycle after an add transfer or after the resolve step
  assign rsp_valid_d = (accept && (req_i.opcode != iur_pkg::OP_LOOKUP))
                       || (state_q == S_RESOLVE);

  assign unit_wdata  = '{segment: req_i.segment, all_flag: req_i.include_all};
  assign range_wdata = '{first: req_i.range_start, last: req_i.range_end,
                         owner: req_i.unit};
  assign dev_wdata   = '{bus: req_i.bus, devfn: req_i.devfn, owner: req_i.unit};

  // answer to an add command, sent the cycle after its transfer
  always_comb begin
    add_rsp = '{status: iur_pkg::STATUS_OK, unit_index: '0};
    unique case (req_i.opcode)
      iur_pkg::OP_ADD_UNIT: begin
        if (unit_full) begin
          add_rsp.status = iur_pkg::STATUS_FULL;
        end else begin
          add_rsp.unit_index = iur_pkg::unit_t'(unit_cnt_q);
        end
      end
      iur_pkg::OP_ADD_RANGE: begin
        priority if (unit_unknown) add_rsp.status = iur_pkg::STATUS_UNKNOWN;
        else if (range_full)       add_rsp.status = iur_pkg::STATUS_FULL;
        else                       add_rsp.status = iur_pkg::STATUS_OK;
      end
      iur_pkg::OP_ADD_DEVICE: begin
        priority if (unit_unknown) add_rsp.status = iur_pkg::STATUS_UNKNOWN;
        else if (dev_full)         add_rsp.status = iur_pkg::STATUS_FULL;
        else                       add_rsp.status = iur_pkg::STATUS_OK;
      end
      default: begin
        add_rsp = '{status: iur_pkg::STATUS_OK, unit_index: '0};
      end
    endcase
  end

  // final priority: explicit device, then lowest unit with a covering range,
  // then the last include-all unit of the segment
  always_comb begin
    iur_pkg::unit_t low_range;
    iur_pkg::unit_t high_all;
    logic           any_all;
    low_range = '0;
    high_all  = '0;
    any_all   = 1'b0;
    for (int i = iur_pkg::UnitCodes - 1; i >= 0; i--) begin
      if (range_mask_q[i]) low_range = iur_pkg::unit_t'(i);
    end
    for (int i = 0; i < iur_pkg::UnitCodes; i++) begin
      if (all_mask_q[i]) begin
        high_all = iur_pkg::unit_t'(i);
        any_all  = 1'b1;
      end
    end
    priority if (dev_hit_q) begin
      lookup_rsp = '{status: iur_pkg::STATUS_OK, unit_index: dev_unit_q};
    end else if (range_mask_q != '0) begin
      lookup_rsp = '{status: iur_pkg::STATUS_OK, unit_index: low_range};
    end else if (any_all) begin
      lookup_rsp = '{status: iur_pkg::STATUS_OK, unit_index: high_all};
    end else begin
      lookup_rsp = '{status: iur_pkg::STATUS_NOT_FOUND, unit_index: '0};
    end
  end

  // table memories, all read through the sweep counter
  iur_ram #(.Width(UEW), .Depth(MAX_UNITS)) u_unit_ram (
    .clk_i   (clk_i),
    .we_i    (unit_we),
    .waddr_i (unit_cnt_q[UAW-1:0]),
    .wdata_i (unit_wdata),
    .raddr_i (scan_q[UAW-1:0]),
    .rdata_o (unit_rdata)
  );

  iur_ram #(.Width(REW), .Depth(MAX_RANGES)) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (range_we),
    .waddr_i (range_cnt_q[RAW-1:0]),
    .wdata_i (range_wdata),
    .raddr_i (scan_q[RAW-1:0]),
    .rdata_o (range_rdata)
  );

  iur_ram #(.Width(DEW), .Depth(MAX_DEVICES)) u_dev_ram (
    .clk_i   (clk_i),
    .we_i    (dev_we),
    .waddr_i (dev_cnt_q[DAW-1:0]),
    .wdata_i (dev_wdata),
    .raddr_i (scan_q[DAW-1:0]),
    .rdata_o (dev_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      unit_cnt_q  <= '0;
      range_cnt_q <= '0;
      dev_cnt_q   <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (unit_we)  unit_cnt_q  <= unit_cnt_q + UCW'(1);
      if (range_we) range_cnt_q <= range_cnt_q + RCW'(1);
      if (dev_we)   dev_cnt_q   <= dev_cnt_q + DCW'(1);

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req_i.opcode == iur_pkg::OP_LOOKUP) begin
              // latch key and clear evidence, then sweep the unit table
              seg_q        <= req_i.segment;
              bus_q        <= req_i.bus;
              devfn_q      <= req_i.devfn;
              seg_mask_q   <= '0;
              all_mask_q   <= '0;
              range_mask_q <= '0;
              dev_hit_q    <= 1'b0;
              dev_unit_q   <= '0;
              scan_q       <= '0;
              pend_q       <= 1'b0;
              state_q      <= S_UNITS;
            end else begin
              rsp_q <= add_rsp;
            end
          end
        end

        S_UNITS: begin
          if (pend_q) begin
            seg_mask_q[pidx_q] <= (unit_rdata.segment == seg_q);
            all_mask_q[pidx_q] <= (unit_rdata.segment == seg_q) && unit_rdata.all_flag;
          end
          if (scan_q < SW'(unit_cnt_q)) begin
            pidx_q <= iur_pkg::unit_t'(scan_q);
            scan_q <= scan_q + SW'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              scan_q  <= '0;
              state_q <= S_RANGES;
            end
          end
        end

        S_RANGES: begin
          if (pend_q && seg_mask_q[range_rdata.owner]
              && (range_rdata.first <= bus_q) && (bus_q <= range_rdata.last)) begin
            range_mask_q[range_rdata.owner] <= 1'b1;
          end
          if (scan_q < SW'(range_cnt_q)) begin
            scan_q <= scan_q + SW'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              scan_q  <= '0;
              state_q <= S_DEVICES;
            end
          end
        end

        S_DEVICES: begin
          // first match in insertion order wins
          if (pend_q && !dev_hit_q && seg_mask_q[dev_rdata.owner]
              && (dev_rdata.bus == bus_q) && (dev_rdata.devfn == devfn_q)) begin
            dev_hit_q  <= 1'b1;
            dev_unit_q <= dev_rdata.owner;
          end
          if (scan_q < SW'(dev_cnt_q)) begin
            scan_q <= scan_q + SW'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              scan_q  <= '0;
              state_q <= S_RESOLVE;
            end
          end
        end

        S_RESOLVE: begin
          rsp_q   <= lookup_rsp;
          state_q <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== sim/iommu_unit_resolver_core_tb.sv =====
module iommu_unit_resolver_core_tb;

  // random commands after the directed rows
  localparam int unsigned NumRandom   = 1000;
  // a lookup over full tables answers well within this drain, so it covers any straggler
  localparam int unsigned DrainCycles = 80;
  // items in this window are sent back to back with no idle cycles
  localparam int unsigned BurstFirst  = 300;
  localparam int unsigned BurstLast   = 499;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  iur_pkg::req_t  req_i;
  logic           rsp_valid_o;
  iur_pkg::rsp_t  rsp_o;

  iommu_unit_resolver_core uut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .rsp_valid_o,
    .rsp_o
  );

  // one directed row: the command, plus an answer typed in where it is obvious
  typedef struct {
    iur_pkg::req_t  cmd;
    logic           pinned;
    iur_pkg::rsp_t  answer;
  } step_t;

  // shadow copy of the three tables, updated at every command transfer
  logic [15:0]    seg_of_unit [iur_pkg::MaxUnitsDef];
  logic           all_of_unit [iur_pkg::MaxUnitsDef];
  logic [7:0]     rng_lo      [iur_pkg::MaxRangesDef];
  logic [7:0]     rng_hi      [iur_pkg::MaxRangesDef];
  iur_pkg::unit_t rng_unit    [iur_pkg::MaxRangesDef];
  logic [7:0]     dev_bus     [iur_pkg::MaxDevicesDef];
  logic [7:0]     dev_fn      [iur_pkg::MaxDevicesDef];
  iur_pkg::unit_t dev_unit    [iur_pkg::MaxDevicesDef];
  int unsigned n_units;
  int unsigned n_ranges;
  int unsigned n_devs;

  // answers still owed by the block, oldest first
  iur_pkg::rsp_t answer_q [$];
  int unsigned   errors;

  // typed-in answer of the row currently on the command port
  logic          pin_valid;
  iur_pkg::rsp_t pin_rsp;

  step_t       plan [$];

  // work out the answer to one command and apply its effect on the tables
  function automatic iur_pkg::rsp_t resolve_cmd(iur_pkg::req_t c);
    iur_pkg::rsp_t  a;
    logic           have_all;
    iur_pkg::unit_t all_idx;
    int    i;
    int    j;
    a.status     = iur_pkg::STATUS_OK;
    a.unit_index = '0;
    have_all     = 1'b0;
    all_idx      = '0;
    case (iur_pkg::op_e'(c.opcode))
      iur_pkg::OP_ADD_UNIT: begin
        if (n_units >= iur_pkg::MaxUnitsDef) begin
          a.status = iur_pkg::STATUS_FULL;
        end else begin
          seg_of_unit[n_units] = c.segment;
          all_of_unit[n_units] = c.include_all;
          a.unit_index         = iur_pkg::unit_t'(n_units);
          n_units++;
        end
      end
      iur_pkg::OP_ADD_RANGE: begin
        // unknown owner wins over a full table
        if (c.unit >= n_units) begin
          a.status = iur_pkg::STATUS_UNKNOWN;
        end else if (n_ranges >= iur_pkg::MaxRangesDef) begin
          a.status = iur_pkg::STATUS_FULL;
        end else begin
          rng_lo[n_ranges]   = c.range_start;
          rng_hi[n_ranges]   = c.range_end;
          rng_unit[n_ranges] = c.unit;
          n_ranges++;
        end
      end
      iur_pkg::OP_ADD_DEVICE: begin
        if (c.unit >= n_units) begin
          a.status = iur_pkg::STATUS_UNKNOWN;
        end else if (n_devs >= iur_pkg::MaxDevicesDef) begin
          a.status = iur_pkg::STATUS_FULL;
        end else begin
          dev_bus[n_devs]  = c.bus;
          dev_fn[n_devs]   = c.devfn;
          dev_unit[n_devs] = c.unit;
          n_devs++;
        end
      end
      default: begin
        // explicit devices first, earliest entry wins
        for (i = 0; i < int'(n_devs); i++) begin
          if (seg_of_unit[dev_unit[i]] == c.segment && dev_bus[i] == c.bus &&
              dev_fn[i] == c.devfn) begin
            a.unit_index = dev_unit[i];
            return a;
          end
        end
        // then bus ranges, lowest unit first; note the last include-all unit
        for (i = 0; i < int'(n_units); i++) begin
          if (seg_of_unit[i] == c.segment) begin
            for (j = 0; j < int'(n_ranges); j++) begin
              // a reversed range holds no bus at all
              if (rng_unit[j] == iur_pkg::unit_t'(i) && rng_lo[j] <= c.bus &&
                  c.bus <= rng_hi[j]) begin
                a.unit_index = iur_pkg::unit_t'(i);
                return a;
              end
            end
            if (all_of_unit[i]) begin
              have_all = 1'b1;
              all_idx  = iur_pkg::unit_t'(i);
            end
          end
        end
        if (have_all) begin
          a.unit_index = all_idx;
        end else begin
          a.status = iur_pkg::STATUS_NOT_FOUND;
        end
      end
    endcase
    return a;
  endfunction

  function automatic step_t mk(iur_pkg::op_e op, logic [15:0] seg, logic [7:0] bus,
                               logic [7:0] devfn, iur_pkg::unit_t unit, logic all,
                               logic [7:0] rs, logic [7:0] re, logic pinned,
                               iur_pkg::status_e st, iur_pkg::unit_t idx);
    step_t s;
    s.cmd                = '0;
    s.cmd.opcode         = op;
    s.cmd.segment        = seg;
    s.cmd.bus            = bus;
    s.cmd.devfn          = devfn;
    s.cmd.unit           = unit;
    s.cmd.include_all    = all;
    s.cmd.range_start    = rs;
    s.cmd.range_end      = re;
    s.pinned             = pinned;
    s.answer.status      = st;
    s.answer.unit_index  = idx;
    return s;
  endfunction

  // append one directed row to the plan
  function automatic void queue_row(step_t s);
    plan = {plan, s};
  endfunction

  // segments cluster on the extremes and on ones already in use, so lookups hit
  function automatic logic [15:0] pick_segment();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) begin
      return 16'h0000;
    end else if (p < 60) begin
      return 16'hffff;
    end else if (p < 80 && n_units > 0) begin
      return seg_of_unit[$urandom_range(0, n_units - 1)];
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // mostly a unit that exists, sometimes any code so unknown owners show up
  function automatic iur_pkg::unit_t pick_owner();
    if (n_units > 0 && $urandom_range(0, 99) < 85) begin
      return iur_pkg::unit_t'($urandom_range(0, n_units - 1));
    end
    return iur_pkg::unit_t'($urandom_range(0, iur_pkg::UnitCodes - 1));
  endfunction

  function automatic iur_pkg::req_t random_cmd();
    iur_pkg::req_t c;
    logic [63:0]   raw;
    int unsigned   r;
    int unsigned   p;
    int unsigned   j;
    int unsigned   lo;
    // fields the opcode ignores keep these random bits
    raw = {$urandom, $urandom};
    c   = raw[$bits(iur_pkg::req_t)-1:0];
    r   = $urandom_range(0, 99);
    // the last unit is held back until ranges and devices are full, so that
    // naming it exercises the unknown-before-full ordering
    if (r < 5 && (n_units < iur_pkg::MaxUnitsDef - 1 ||
                  (n_ranges == iur_pkg::MaxRangesDef &&
                   n_devs == iur_pkg::MaxDevicesDef))) begin
      c.opcode  = iur_pkg::OP_ADD_UNIT;
      c.segment = pick_segment();
    end else if (r < 25) begin
      c.opcode = iur_pkg::OP_ADD_RANGE;
      c.unit   = pick_owner();
      p        = $urandom_range(0, 9);
      if (p < 7) begin
        lo            = $urandom_range(0, 255);
        c.range_start = 8'(lo);
        c.range_end   = 8'($urandom_range(lo, 255));
      end else if (p == 7) begin
        c.range_start = 8'h00;
        c.range_end   = 8'hff;
      end
    end else if (r < 45) begin
      c.opcode = iur_pkg::OP_ADD_DEVICE;
      c.unit   = pick_owner();
      if ($urandom_range(0, 1) == 1) begin
        c.bus = 8'($urandom_range(0, 7));
      end
    end else begin
      c.opcode = iur_pkg::OP_LOOKUP;
      p        = $urandom_range(0, 99);
      if (p < 40 && n_devs > 0) begin
        // aim at a stored device, usually from its owner's segment
        j       = $urandom_range(0, n_devs - 1);
        c.bus   = dev_bus[j];
        c.devfn = dev_fn[j];
        c.segment = ($urandom_range(0, 3) != 0) ? seg_of_unit[dev_unit[j]] : pick_segment();
      end else if (p < 75) begin
        c.segment = pick_segment();
        if ($urandom_range(0, 1) == 1) begin
          c.bus = 8'($urandom_range(0, 7));
        end
      end
    end
    return c;
  endfunction

  // present one command from a falling edge and hold it until its transfer
  task automatic send(step_t s, bit may_idle);
    int unsigned gap;
    gap = (may_idle && $urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    req_i     <= s.cmd;
    pin_valid  = s.pinned;
    pin_rsp    = s.answer;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result checking and command tracking, both at the rising edge
  always @(posedge clk_i) begin : monitor
    iur_pkg::rsp_t want;
    iur_pkg::rsp_t got;
    if (rsp_valid_o === 1'b1) begin
      got = rsp_o;
      if (answer_q.size() == 0) begin
        $error("result with nothing outstanding: status %0d unit_index %0d",
               got.status, got.unit_index);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.unit_index !== want.unit_index) begin
          $error("unit_index: expected %0d, got %0d", want.unit_index, got.unit_index);
          errors++;
        end
      end
    end
    // command transfer: the shadow tables always advance, the typed-in answer
    // takes the place of the predicted one on pinned rows
    if (rst_ni && start && busy === 1'b0) begin
      want     = resolve_cmd(req_i);
      answer_q = {answer_q, (pin_valid ? pin_rsp : want)};
    end
  end

  initial begin : stimulus
    step_t s;
    int unsigned k;
    rst_ni    = 1'b0;
    start     = 1'b0;
    req_i     = '0;
    pin_valid = 1'b0;
    pin_rsp   = '0;
    errors    = 0;
    n_units   = 0;
    n_ranges  = 0;
    n_devs    = 0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: empty tables, unknown owners, extremes, each priority level
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'h0000, 8'h00, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_NOT_FOUND, 3'd0));
    queue_row(mk(iur_pkg::OP_ADD_RANGE,  16'h0000, 8'h00, 8'h00, 3'd0, 1'b0, 8'h00, 8'hff,
                 1'b1, iur_pkg::STATUS_UNKNOWN, 3'd0));
    queue_row(mk(iur_pkg::OP_ADD_DEVICE, 16'h0000, 8'hff, 8'hff, 3'd7, 1'b0, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_UNKNOWN, 3'd0));
    queue_row(mk(iur_pkg::OP_ADD_UNIT,   16'h0000, 8'h00, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_ADD_UNIT,   16'hffff, 8'h00, 8'h00, 3'd0, 1'b1, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_OK, 3'd1));
    queue_row(mk(iur_pkg::OP_ADD_RANGE,  16'h0000, 8'h00, 8'h00, 3'd0, 1'b0, 8'h00, 8'hff,
                 1'b1, iur_pkg::STATUS_OK, 3'd0));
    // reversed range: stored, but covers no bus
    queue_row(mk(iur_pkg::OP_ADD_RANGE,  16'h0000, 8'h00, 8'h00, 3'd1, 1'b0, 8'h80, 8'h10,
                 1'b1, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_ADD_DEVICE, 16'h0000, 8'hff, 8'hff, 3'd1, 1'b0, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_ADD_DEVICE, 16'h0000, 8'h01, 8'h01, 3'd2, 1'b0, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_UNKNOWN, 3'd0));
    // explicit device, reversed range falling through to include-all, range hit
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'hffff, 8'hff, 8'hff, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'hffff, 8'h20, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'h0000, 8'hff, 8'hff, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'hffff, 8'hff, 8'hfe, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'h1234, 8'h00, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_NOT_FOUND, 3'd0));
    // a second include-all unit on the same segment
    queue_row(mk(iur_pkg::OP_ADD_UNIT,   16'hffff, 8'h00, 8'h00, 3'd0, 1'b1, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_OK, 3'd2));
    queue_row(mk(iur_pkg::OP_ADD_RANGE,  16'h0000, 8'h00, 8'h00, 3'd2, 1'b0, 8'h20, 8'h20,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'hffff, 8'h20, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'hffff, 8'h21, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_ADD_UNIT,   16'h1234, 8'h00, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b1, iur_pkg::STATUS_OK, 3'd3));
    queue_row(mk(iur_pkg::OP_ADD_DEVICE, 16'h0000, 8'h00, 8'h00, 3'd3, 1'b0, 8'h00, 8'h00,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));
    queue_row(mk(iur_pkg::OP_LOOKUP,     16'h1234, 8'h00, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00,
                 1'b0, iur_pkg::STATUS_OK, 3'd0));

    foreach (plan[i]) begin
      send(plan[i], 1'b1);
    end

    // random part: tables fill up early, then lookups and refused adds dominate
    s.pinned = 1'b0;
    s.answer = '0;
    for (k = 0; k < NumRandom; k++) begin
      s.cmd = random_cmd();
      send(s, !(k >= BurstFirst && k <= BurstLast));
    end

    @(negedge clk_i);
    start     <= 1'b0;
    pin_valid  = 1'b0;

    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("iommu_unit_resolver_core regression: pass");
    end else begin
      $display("iommu_unit_resolver_core regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("iommu_unit_resolver_core regression: fail");
    $finish;
  end

endmodule
